// ----- src/assert_macros.svh -----
// Concurrent assertion helpers, compiled out with NO_ASSERTIONS
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TAMM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("tamm assertion failed");
`define TAMM_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("tamm forbidden condition seen");
`else
`define TAMM_ASSERT(lbl, clk, rst_n, prop)
`define TAMM_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ----- src/tamm_pkg.sv -----
package tamm_pkg;

  localparam int unsigned DataW       = 32;
  localparam int unsigned AddrW       = 8;
  localparam int unsigned CmdW        = 3;
  localparam int unsigned StatusW     = 2;
  localparam int unsigned MemWordsDef = 256;
  localparam int unsigned AddrSpan    = 1 << AddrW;
  localparam int unsigned QueueDepth  = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD   = 3'd0,
    CMD_SUB   = 3'd1,
    CMD_MUL   = 3'd2,
    CMD_DIV   = 3'd3,
    CMD_READ  = 3'd5,
    CMD_WRITE = 3'd6,
    CMD_STORE = 3'd7
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_DONE    = 2'd0,
    ST_VALID   = 2'd1,
    ST_BADOP   = 2'd2,
    ST_DIVZERO = 2'd3
  } status_e;

  // operation class handed from front to back
  typedef enum logic [2:0] {
    K_ADD,
    K_SUB,
    K_MUL,
    K_DIV,
    K_READ,
    K_WRITE,
    K_STORE,
    K_BAD
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [AddrW-1:0] dest;
    logic [AddrW-1:0] src_a;
    logic [AddrW-1:0] src_b;
    logic [DataW-1:0] value;
  } uop_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [DataW-1:0] wdata;
    logic [AddrW-1:0] raddr_a;
    logic [AddrW-1:0] raddr_b;
  } ram_req_t;

endpackage

// ----- src/tamm_if.sv -----
interface tamm_req_if;
  import tamm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CmdW-1:0]         cmd;
  logic [AddrW-1:0]        dest_addr;
  logic [AddrW-1:0]        src_a_addr;
  logic [AddrW-1:0]        src_b_addr;
  logic signed [DataW-1:0] immediate;
  logic signed [DataW-1:0] read_value;

  modport source (
    output valid, cmd, dest_addr, src_a_addr, src_b_addr, immediate, read_value,
    input  ready
  );
  modport sink (
    input  valid, cmd, dest_addr, src_a_addr, src_b_addr, immediate, read_value,
    output ready
  );
endinterface

interface tamm_rsp_if;
  import tamm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [StatusW-1:0]      status;
  logic signed [DataW-1:0] out_value;

  modport source (
    output valid, status, out_value,
    input  ready
  );
  modport sink (
    input  valid, status, out_value,
    output ready
  );
endinterface

// ----- src/three_address_memory_machine_unit.sv -----
// Three-address memory machine: one instruction per beat on req_i, one result
// beat per instruction on rsp_o, in order.
// req_i carries cmd, three 8-bit addresses, an immediate and a read value;
// addresses fold onto MemWords words. rsp_o carries status and out_value.
// A front stage classifies each beat and parks it in a two-entry queue; the
// back end reads both operands from the data RAM, executes and writes back.
// The back end steps through S_IDLE, S_EXEC and S_FIN, and for a divide also waits
// in S_DIV while the 32-step shift-subtract divider runs; it takes no new
// instruction until its result is loaded, while the queue takes beats until full.
// Reset clears the per-word valid bits at once, so every word reads as zero
// and req_i.ready is high in the first cycle after reset; no clearing sweep.
// When the receiver stalls, the result holds in the output register, the back
// end waits with its next result ready to load, and the queue takes up to two
// more request beats before req_i.ready drops.
`include "assert_macros.svh"

module three_address_memory_machine_unit #(
  parameter int unsigned MemWords = tamm_pkg::MemWordsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tamm_req_if.sink   req_i,
  tamm_rsp_if.source rsp_o
);
  import tamm_pkg::*;

  localparam int unsigned Depth = (MemWords < AddrSpan) ? MemWords : AddrSpan;
  localparam int unsigned IdxW  = $clog2(Depth);

  logic             uop_valid;
  uop_t             uop;
  logic             uop_pop;
  ram_req_t         ram_req;
  logic [DataW-1:0] rdata_a, rdata_b;

  tamm_front #(
    .MemWords (MemWords)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .uop_valid_o (uop_valid),
    .uop_o       (uop),
    .uop_pop_i   (uop_pop)
  );

  tamm_ram #(
    .Width (DataW),
    .Depth (Depth)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_req.we),
    .waddr_i   (ram_req.waddr[IdxW-1:0]),
    .wdata_i   (ram_req.wdata),
    .raddr_a_i (ram_req.raddr_a[IdxW-1:0]),
    .raddr_b_i (ram_req.raddr_b[IdxW-1:0]),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  tamm_back #(
    .Depth (Depth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .uop_valid_i (uop_valid),
    .uop_i       (uop),
    .uop_pop_o   (uop_pop),
    .ram_o       (ram_req),
    .rdata_a_i   (rdata_a),
    .rdata_b_i   (rdata_b),
    .rsp_o       (rsp_o)
  );

  `TAMM_ASSERT(a_pop_needs_entry, clk_i, rst_ni, uop_pop |-> uop_valid)
  `TAMM_ASSERT(a_write_loads_result, clk_i, rst_ni, ram_req.we |=> rsp_o.valid)
  `TAMM_NEVER(a_no_write_on_pop, clk_i, rst_ni, ram_req.we && uop_pop)

endmodule

// ----- src/tamm_ram.sv -----
module tamm_ram #(
  parameter int unsigned Width = tamm_pkg::DataW,
  parameter int unsigned Depth = tamm_pkg::MemWordsDef
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ----- src/tamm_front.sv -----
module tamm_front #(
  parameter int unsigned MemWords = tamm_pkg::MemWordsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  tamm_req_if.sink       req_i,
  output logic           uop_valid_o,
  output tamm_pkg::uop_t uop_o,
  input  logic           uop_pop_i
);
  import tamm_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic [AddrW-1:0] wrap_lut [AddrSpan];
  uop_t             entry;
  uop_t             fifo_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q, count_d;
  logic             push;

  // fold the 8-bit address space onto the memory size
  for (genvar i = 0; i < AddrSpan; i++) begin : g_wrap
    localparam int unsigned Wrapped = i % MemWords;
    assign wrap_lut[i] = AddrW'(Wrapped);
  end

  always_comb begin
    entry       = '0;
    entry.dest  = wrap_lut[req_i.dest_addr];
    entry.src_a = wrap_lut[req_i.src_a_addr];
    entry.src_b = wrap_lut[req_i.src_b_addr];
    unique case (req_i.cmd)
      CMD_ADD:   entry.kind = K_ADD;
      CMD_SUB:   entry.kind = K_SUB;
      CMD_MUL:   entry.kind = K_MUL;
      CMD_DIV:   entry.kind = K_DIV;
      CMD_READ: begin
        entry.kind  = K_READ;
        entry.value = req_i.read_value;
      end
      CMD_WRITE: entry.kind = K_WRITE;
      CMD_STORE: begin
        entry.kind  = K_STORE;
        entry.value = req_i.immediate;
      end
      default:   entry.kind = K_BAD;
    endcase
  end

  assign req_i.ready = (count_q != CntW'(QueueDepth));
  assign push        = req_i.valid && req_i.ready;
  assign count_d     = count_q + CntW'(push) - CntW'(uop_pop_i);
  assign uop_valid_o = (count_q != '0);
  assign uop_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (uop_pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= entry;
    end
  end

endmodule

// ----- src/tamm_div.sv -----
module tamm_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [tamm_pkg::DataW-1:0] dividend_i,
  input  logic [tamm_pkg::DataW-1:0] divisor_i,
  output logic                       done_o,
  output logic [tamm_pkg::DataW-1:0] quot_o
);
  import tamm_pkg::*;

  localparam int unsigned CntW = $clog2(DataW);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_e;

  state_e           state_q;
  logic [CntW-1:0]  cnt_q;
  logic [DataW-1:0] quo_q, rem_q, den_q;
  logic             neg_q;
  logic [DataW:0]   rem_sh, diff;
  logic             fits;

  // one restoring shift-subtract step per cycle on magnitudes
  assign rem_sh = {rem_q, quo_q[DataW-1]};
  assign diff   = rem_sh - {1'b0, den_q};
  assign fits   = !diff[DataW];

  assign done_o = (state_q == S_DONE);
  assign quot_o = neg_q ? ('0 - quo_q) : quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      quo_q   <= '0;
      rem_q   <= '0;
      den_q   <= '0;
      neg_q   <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            quo_q   <= dividend_i[DataW-1] ? ('0 - dividend_i) : dividend_i;
            den_q   <= divisor_i[DataW-1] ? ('0 - divisor_i) : divisor_i;
            rem_q   <= '0;
            neg_q   <= dividend_i[DataW-1] ^ divisor_i[DataW-1];
            cnt_q   <= '0;
            state_q <= S_RUN;
          end
        end
        S_RUN: begin
          rem_q <= fits ? diff[DataW-1:0] : rem_sh[DataW-1:0];
          quo_q <= {quo_q[DataW-2:0], fits};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(DataW - 1)) begin
            state_q <= S_DONE;
          end
        end
        S_DONE:  state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/tamm_back.sv -----
module tamm_back #(
  parameter int unsigned Depth = tamm_pkg::MemWordsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       uop_valid_i,
  input  tamm_pkg::uop_t             uop_i,
  output logic                       uop_pop_o,
  output tamm_pkg::ram_req_t         ram_o,
  input  logic [tamm_pkg::DataW-1:0] rdata_a_i,
  input  logic [tamm_pkg::DataW-1:0] rdata_b_i,
  tamm_rsp_if.source                 rsp_o
);
  import tamm_pkg::*;

  localparam int unsigned IdxW = $clog2(Depth);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_FIN
  } state_e;

  state_e           state_q;
  uop_t             cur_q;
  logic [Depth-1:0] vld_q;
  logic             vld_a_q, vld_b_q;
  logic [DataW-1:0] res_q;
  logic             wr_q;
  status_e          st_q;
  logic             out_vld_q;
  status_e          out_st_q;
  logic [DataW-1:0] out_val_q;

  logic [DataW-1:0] op_a, op_b;
  logic             out_free;
  logic             div_start, div_done;
  logic [DataW-1:0] div_quot;

  // words never written read as zero
  assign op_a = vld_a_q ? rdata_a_i : '0;
  assign op_b = vld_b_q ? rdata_b_i : '0;

  assign out_free  = !out_vld_q || rsp_o.ready;
  assign uop_pop_o = (state_q == S_IDLE) && uop_valid_i;
  assign div_start = (state_q == S_EXEC) && (cur_q.kind == K_DIV) && (op_b != '0);

  always_comb begin
    ram_o         = '0;
    ram_o.raddr_a = (uop_i.kind == K_WRITE) ? uop_i.dest : uop_i.src_a;
    ram_o.raddr_b = uop_i.src_b;
    ram_o.we      = (state_q == S_FIN) && out_free && wr_q;
    ram_o.waddr   = cur_q.dest;
    ram_o.wdata   = res_q;
  end

  assign rsp_o.valid     = out_vld_q;
  assign rsp_o.status    = out_st_q;
  assign rsp_o.out_value = out_val_q;

  tamm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (op_a),
    .divisor_i  (op_b),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cur_q     <= '0;
      vld_q     <= '0;
      vld_a_q   <= 1'b0;
      vld_b_q   <= 1'b0;
      res_q     <= '0;
      wr_q      <= 1'b0;
      st_q      <= ST_DONE;
      out_vld_q <= 1'b0;
      out_st_q  <= ST_DONE;
      out_val_q <= '0;
    end else begin
      if (out_vld_q && rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (uop_valid_i) begin
            cur_q   <= uop_i;
            vld_a_q <= vld_q[ram_o.raddr_a[IdxW-1:0]];
            vld_b_q <= vld_q[ram_o.raddr_b[IdxW-1:0]];
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          wr_q    <= 1'b1;
          st_q    <= ST_DONE;
          state_q <= S_FIN;
          unique case (cur_q.kind) inside
            K_ADD: res_q <= op_a + op_b;
            K_SUB: res_q <= op_a - op_b;
            K_MUL: res_q <= op_a * op_b;
            K_DIV: begin
              if (op_b == '0) begin
                wr_q <= 1'b0;
                st_q <= ST_DIVZERO;
              end else begin
                state_q <= S_DIV;
              end
            end
            K_READ, K_STORE: res_q <= cur_q.value;
            K_WRITE: begin
              wr_q  <= 1'b0;
              st_q  <= ST_VALID;
              res_q <= op_a;
            end
            default: begin
              wr_q <= 1'b0;
              st_q <= ST_BADOP;
            end
          endcase
        end
        S_DIV: begin
          if (div_done) begin
            res_q   <= div_quot;
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          // hold until the output register is free
          if (out_free) begin
            out_vld_q <= 1'b1;
            out_st_q  <= st_q;
            out_val_q <= (st_q == ST_VALID) ? res_q : '0;
            if (wr_q) begin
              vld_q[cur_q.dest[IdxW-1:0]] <= 1'b1;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import tamm_pkg::*;

  localparam int unsigned RandomItems = 1725;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned SettleTail  = 60;
  localparam logic [CmdW-1:0] CmdUnused = 3'd4;

  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [AddrW-1:0] dest;
    logic [AddrW-1:0] src_a;
    logic [AddrW-1:0] src_b;
    logic [DataW-1:0] imm;
    logic [DataW-1:0] rd_val;
  } instr_t;

  typedef struct packed {
    status_e          status;
    logic [DataW-1:0] value;
  } outcome_t;

  // Mirror of the data memory plus the results still owed by the block.
  class machine_model;
    logic [DataW-1:0] words [MemWordsDef];
    outcome_t         owed [$];
    int unsigned      faults;

    function new();
      foreach (words[i]) words[i] = '0;
      faults = 0;
    endfunction

    function int unsigned pending();
      return owed.size();
    endfunction

    function void note_request(instr_t ins);
      logic [DataW-1:0] a, b, mag_a, mag_b, quo;
      outcome_t         o;
      // read both sources before the destination is touched
      a = words[ins.src_a];
      b = words[ins.src_b];
      o.status = ST_DONE;
      o.value  = '0;
      case (ins.cmd)
        CMD_ADD:   words[ins.dest] = a + b;
        CMD_SUB:   words[ins.dest] = a - b;
        CMD_MUL:   words[ins.dest] = a * b;
        CMD_DIV: begin
          if (b == '0) begin
            o.status = ST_DIVZERO;
          end else begin
            mag_a = a[DataW-1] ? -a : a;
            mag_b = b[DataW-1] ? -b : b;
            quo   = mag_a / mag_b;
            words[ins.dest] = (a[DataW-1] != b[DataW-1]) ? -quo : quo;
          end
        end
        CMD_READ:  words[ins.dest] = ins.rd_val;
        CMD_WRITE: begin
          o.status = ST_VALID;
          o.value  = words[ins.dest];
        end
        CMD_STORE: words[ins.dest] = ins.imm;
        default:   o.status = ST_BADOP;
      endcase
      owed.push_back(o);
    endfunction

    function void flag(string msg);
      faults++;
      if (faults <= 10) $display("%t mismatch: %s", $realtime, msg);
    endfunction

    function void check_result(logic [StatusW-1:0] st, logic [DataW-1:0] val);
      outcome_t o;
      if (owed.size() == 0) begin
        flag($sformatf("unexpected result status %0d value %h", st, val));
        return;
      end
      o = owed.pop_front();
      if (st !== o.status)
        flag($sformatf("status expected %0d got %0d", o.status, st));
      if (val !== o.value)
        flag($sformatf("out_value expected %h got %h", o.value, val));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  bit          hold_off_req = 1'b0;
  int unsigned quiet_cycles = 0;
  machine_model book = new();

  tamm_req_if req_bus ();
  tamm_rsp_if rsp_bus ();

  three_address_memory_machine_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  always #2 clk_i = ~clk_i;

  function automatic instr_t mk(logic [CmdW-1:0] cmd, int unsigned d, int unsigned a,
                                int unsigned b, logic [DataW-1:0] imm,
                                logic [DataW-1:0] rd_val);
    instr_t ins;
    ins.cmd    = cmd;
    ins.dest   = d[AddrW-1:0];
    ins.src_a  = a[AddrW-1:0];
    ins.src_b  = b[AddrW-1:0];
    ins.imm    = imm;
    ins.rd_val = rd_val;
    return ins;
  endfunction

  // Mostly a small working set so that operands are words already written.
  function automatic logic [AddrW-1:0] pick_addr();
    if ($urandom_range(0, 9) < 8) return AddrW'($urandom_range(0, 15));
    return AddrW'($urandom_range(0, 255));
  endfunction

  function automatic logic [DataW-1:0] pick_word();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 3) return $urandom_range(0, 40) - 20;
    if (r == 3) begin
      case ($urandom_range(0, 3))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return 32'hFFFF_FFFF;
        default: return 32'h0000_0001;
      endcase
    end
    return $urandom();
  endfunction

  function automatic instr_t random_instr();
    instr_t      ins;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 12)      ins.cmd = CMD_ADD;
    else if (pick < 22) ins.cmd = CMD_SUB;
    else if (pick < 32) ins.cmd = CMD_MUL;
    else if (pick < 47) ins.cmd = CMD_DIV;
    else if (pick < 57) ins.cmd = CMD_READ;
    else if (pick < 80) ins.cmd = CMD_WRITE;
    else if (pick < 94) ins.cmd = CMD_STORE;
    else                ins.cmd = CmdUnused;
    ins.dest   = pick_addr();
    ins.src_a  = pick_addr();
    ins.src_b  = pick_addr();
    ins.imm    = pick_word();
    ins.rd_val = pick_word();
    return ins;
  endfunction

  // Offer one beat and hold it until taken; valid stays high on return.
  task automatic send_instr(instr_t ins);
    req_bus.valid      <= 1'b1;
    req_bus.cmd        <= ins.cmd;
    req_bus.dest_addr  <= ins.dest;
    req_bus.src_a_addr <= ins.src_a;
    req_bus.src_b_addr <= ins.src_b;
    req_bus.immediate  <= ins.imm;
    req_bus.read_value <= ins.rd_val;
    do @(posedge clk_i); while (!req_bus.ready);
  endtask

  task automatic wait_drained();
    req_bus.valid <= 1'b0;
    do @(posedge clk_i); while (book.pending() != 0);
  endtask

  initial begin : sender
    instr_t      plan [$];
    int unsigned burst, gap;
    req_bus.valid      = 1'b0;
    req_bus.cmd        = '0;
    req_bus.dest_addr  = '0;
    req_bus.src_a_addr = '0;
    req_bus.src_b_addr = '0;
    req_bus.immediate  = '0;
    req_bus.read_value = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    plan.push_back(mk(CMD_WRITE, 0, 0, 0, '0, '0));            // untouched word reads zero
    plan.push_back(mk(CMD_STORE, 255, 0, 0, 32'h7FFF_FFFF, '0));
    plan.push_back(mk(CMD_STORE, 0, 0, 0, 32'h8000_0000, '0));
    plan.push_back(mk(CMD_STORE, 1, 0, 0, 32'hFFFF_FFFF, '1));
    plan.push_back(mk(CMD_READ, 3, 0, 0, '0, 32'hA5A5_A5A5));
    plan.push_back(mk(CMD_READ, 4, 0, 0, '1, 32'h5A5A_5A5A));
    plan.push_back(mk(CMD_ADD, 5, 255, 1, '0, '0));
    plan.push_back(mk(CMD_ADD, 6, 255, 255, '0, '0));         // wraps
    plan.push_back(mk(CMD_SUB, 7, 0, 255, '0, '0));
    plan.push_back(mk(CMD_MUL, 8, 255, 255, '0, '0));
    plan.push_back(mk(CMD_DIV, 9, 0, 1, '0, '0));             // most negative over minus one
    plan.push_back(mk(CMD_DIV, 10, 255, 20, '0, '0));         // zero divisor
    plan.push_back(mk(CMD_DIV, 11, 3, 4, '0, '0));            // truncate toward zero
    plan.push_back(mk(CmdUnused, 255, 255, 255, '1, '1));
    plan.push_back(mk(CMD_ADD, 3, 3, 3, '0, '0));             // all three aliased
    plan.push_back(mk(CMD_DIV, 4, 4, 4, '0, '0));
    plan.push_back(mk(CMD_WRITE, 5, 0, 0, '0, '0));
    plan.push_back(mk(CMD_WRITE, 6, 0, 0, '0, '0));
    plan.push_back(mk(CMD_WRITE, 7, 0, 0, '0, '0));
    plan.push_back(mk(CMD_WRITE, 8, 0, 0, '0, '0));
    plan.push_back(mk(CMD_WRITE, 9, 0, 0, '0, '0));
    plan.push_back(mk(CMD_WRITE, 10, 0, 0, '0, '0));
    plan.push_back(mk(CMD_WRITE, 11, 0, 0, '0, '0));
    plan.push_back(mk(CMD_WRITE, 3, 0, 0, '0, '0));
    plan.push_back(mk(CMD_WRITE, 255, 255, 255, '1, '1));
    foreach (plan[i]) send_instr(plan[i]);
    wait_drained();

    burst = 0;
    for (int n = 0; n < RandomItems; n++) begin
      if (n == RandomItems / 3) hold_off_req = 1'b1;
      if (n == 2 * RandomItems / 3) begin
        wait_drained();
      end else if (burst == 0) begin
        burst = $urandom_range(1, 40);
        gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
        if (gap != 0) begin
          req_bus.valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      send_instr(random_instr());
      if (burst != 0) burst--;
    end
    wait_drained();
    repeat (SettleTail) @(posedge clk_i);

    if (book.faults == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : receiver
    int unsigned mode, span;
    rsp_bus.ready = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(5, 60);
      for (int k = 0; k < span; k++) begin
        if (hold_off_req) begin
          hold_off_req = 1'b0;
          // stall long enough for the queue to fill and req_i.ready to drop
          for (int t = 0; t < HoldCycles; t++) begin
            rsp_bus.ready <= 1'b0;
            @(posedge clk_i);
          end
        end
        case (mode)
          0:       rsp_bus.ready <= 1'b1;
          1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
          2:       rsp_bus.ready <= ($urandom_range(0, 3) == 0);
          default: rsp_bus.ready <= (k % 3 != 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_bus.valid && rsp_bus.ready)
      book.check_result(rsp_bus.status, rsp_bus.out_value);
    if (rst_ni && req_bus.valid && req_bus.ready)
      book.note_request(mk(req_bus.cmd, req_bus.dest_addr, req_bus.src_a_addr,
                           req_bus.src_b_addr, req_bus.immediate, req_bus.read_value));
    if (!rst_ni || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == StallLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule
